/* hdl/ltfs_pkg.sv */
// Shared constants, types and control structs for the forward-substitution solver.
package ltfs_pkg;

    localparam int MAX_ORDER = 64;
    localparam int ADDR_W    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    localparam int IDX_W  = 6;
    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int FRAC_W = 16;
    localparam int CNT_W  = $clog2(DATA_W);

    // input tdata layout
    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = ROW_LSB + IDX_W;
    localparam int COEFF_LSB  = COL_LSB + IDX_W;
    localparam int RHS_LSB    = COEFF_LSB + DATA_W;
    localparam int IN_BITS    = RHS_LSB + DATA_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int SOL_IDX_LSB = 0;
    localparam int SOL_VAL_LSB = SOL_IDX_LSB + IDX_W;
    localparam int DZ_BIT      = SOL_VAL_LSB + DATA_W;
    localparam int SAT_BIT     = DZ_BIT + 1;
    localparam int OUT_BITS    = SAT_BIT + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] SOL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SOL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [ACC_W-1:0]  SUM_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]  SUM_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_OFF,
        KIND_DIAG
    } item_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_NUM,
        ST_START,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic acc;
        logic num;
        logic div_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        item_kind_t in_kind;
        logic       coeff_zero;
        logic       div_done;
        logic       out_free;
    } stat_t;

endpackage

/* hdl/ltfs_div.sv */
// Restoring divider, one quotient bit per cycle, with early overflow detection.
module ltfs_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ltfs_pkg::ACC_W-1:0]    dividend,
    input  logic [ltfs_pkg::DATA_W-1:0]   divisor,
    output logic                          done,
    output logic [ltfs_pkg::DATA_W-1:0]   quotient,
    output logic                          overflow
);
    import ltfs_pkg::*;

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              ovf_reg, ovf_next;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;
    logic              fits;

    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});
    assign done      = busy_reg && (cnt_reg == CNT_W'(DATA_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            // upper half already at or above the divisor: quotient needs more than DATA_W bits
            rem_next  = dividend[ACC_W-1:DATA_W];
            quo_next  = dividend[DATA_W-1:0];
            den_next  = divisor;
            ovf_next  = (dividend[ACC_W-1:DATA_W] >= divisor);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            rem_next = fits ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], fits};
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        ovf_reg <= ovf_next;
    end

    assign quotient = quo_reg;
    assign overflow = ovf_reg;

endmodule

/* hdl/ltfs_ctrl.sv */
// Sequencer for item acceptance, multiply-accumulate and diagonal division.
module ltfs_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  ltfs_pkg::stat_t stat,
    output ltfs_pkg::cmd_t  cmd
);
    import ltfs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg) inside
            ST_IDLE, ST_ACC:
            begin
                // accumulate the pending product while taking the next item
                cmd.acc       = (state_reg == ST_ACC);
                s_axis_tready = 1'b1;
                state_next    = ST_IDLE;
                if (s_axis_tvalid)
                begin
                    cmd.accept = 1'b1;
                    unique case (stat.in_kind)
                        KIND_OFF:  state_next = ST_MUL;
                        KIND_DIAG: state_next = ST_NUM;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_NUM:
            begin
                cmd.num    = 1'b1;
                state_next = stat.coeff_zero ? ST_FIN : ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/ltfs_dpath.sv */
// Datapath: solution memory, multiply-accumulate, numerator, divider and output register.
module ltfs_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ltfs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ltfs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  ltfs_pkg::cmd_t                    cmd,
    output ltfs_pkg::stat_t                   stat
);
    import ltfs_pkg::*;

    logic [DATA_W-1:0] sol_mem [MAX_ORDER];

    logic [IDX_W-1:0]         in_row, in_col;
    logic                     in_range;

    logic [IDX_W-1:0]         row_reg;
    logic signed [DATA_W-1:0] coeff_reg;
    logic signed [DATA_W-1:0] rhs_reg;
    logic signed [DATA_W-1:0] xcol_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  prod_next;

    logic [ACC_W-1:0]         row_sum_reg, row_sum_next;
    logic                     sum_sat_reg, sum_sat_next;
    logic [ACC_W-1:0]         sum_raw;
    logic                     sum_ovf;

    logic [ACC_W-1:0]         rhs_q;
    logic [ACC_W-1:0]         num_raw;
    logic                     num_ovf;
    logic [ACC_W-1:0]         num_reg;
    logic                     num_sat_reg;
    logic                     neg_reg;

    logic [ACC_W-1:0]         div_dividend;
    logic [DATA_W-1:0]        div_divisor;
    logic                     div_done;
    logic [DATA_W-1:0]        div_quo;
    logic                     div_ovf;

    logic [DATA_W-1:0]        sol_value;
    logic                     quo_clamp;

    logic                     out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]         out_idx_reg;
    logic [DATA_W-1:0]        out_val_reg;
    logic                     out_dz_reg;
    logic                     out_sat_reg;

    // decode the item on the input bus
    assign in_row   = s_axis_tdata[ROW_LSB +: IDX_W];
    assign in_col   = s_axis_tdata[COL_LSB +: IDX_W];
    assign in_range = (32'(in_row) < 32'(MAX_ORDER)) && (32'(in_col) < 32'(MAX_ORDER));

    always_comb
    begin
        stat.coeff_zero = (coeff_reg == '0);
        stat.div_done   = div_done;
        stat.out_free   = !out_valid_reg || m_axis_tready;
        if (!in_range || (in_col > in_row))
        begin
            stat.in_kind = KIND_SKIP;
        end
        else if (in_col == in_row)
        begin
            stat.in_kind = KIND_DIAG;
        end
        else
        begin
            stat.in_kind = KIND_OFF;
        end
    end

    // exact product of coefficient and stored solution element
    assign prod_next = coeff_reg * xcol_reg;

    // saturating running sum
    assign sum_raw = row_sum_reg + prod_reg;
    assign sum_ovf = (row_sum_reg[ACC_W-1] == prod_reg[ACC_W-1])
                     && (sum_raw[ACC_W-1] != row_sum_reg[ACC_W-1]);

    // numerator rhs * 2^16 - sum, saturating
    assign rhs_q   = {{(ACC_W-DATA_W-FRAC_W){rhs_reg[DATA_W-1]}}, rhs_reg, {FRAC_W{1'b0}}};
    assign num_raw = rhs_q - row_sum_reg;
    assign num_ovf = (rhs_q[ACC_W-1] != row_sum_reg[ACC_W-1])
                     && (num_raw[ACC_W-1] != rhs_q[ACC_W-1]);

    // magnitudes for the unsigned divider
    assign div_dividend = num_reg[ACC_W-1] ? (~num_reg + 1'b1) : num_reg;
    assign div_divisor  = coeff_reg[DATA_W-1] ? (~coeff_reg + 1'b1) : coeff_reg;

    ltfs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo),
        .overflow (div_ovf)
    );

    // sign the quotient and clamp to the Q16.16 range
    always_comb
    begin
        quo_clamp = 1'b0;
        sol_value = '0;
        if (!stat.coeff_zero)
        begin
            if (neg_reg)
            begin
                quo_clamp = div_ovf || (div_quo > SOL_MIN);
                sol_value = quo_clamp ? SOL_MIN : (~div_quo + 1'b1);
            end
            else
            begin
                quo_clamp = div_ovf || div_quo[DATA_W-1];
                sol_value = quo_clamp ? SOL_MAX : div_quo;
            end
        end
    end

    always_comb
    begin
        row_sum_next = row_sum_reg;
        sum_sat_next = sum_sat_reg;
        if (cmd.finish)
        begin
            row_sum_next = '0;
            sum_sat_next = 1'b0;
        end
        else if (cmd.acc)
        begin
            row_sum_next = sum_ovf ? (row_sum_reg[ACC_W-1] ? SUM_MIN : SUM_MAX) : sum_raw;
            sum_sat_next = sum_sat_reg | sum_ovf;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sum_reg   <= '0;
            sum_sat_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_sum_reg   <= row_sum_next;
            sum_sat_reg   <= sum_sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // solution memory: registered read at acceptance, write when a row finishes
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            xcol_reg <= sol_mem[ADDR_W'(in_col)];
        end
        if (cmd.finish)
        begin
            sol_mem[ADDR_W'(row_reg)] <= sol_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg   <= in_row;
            coeff_reg <= s_axis_tdata[COEFF_LSB +: DATA_W];
            rhs_reg   <= s_axis_tdata[RHS_LSB +: DATA_W];
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.num)
        begin
            num_reg     <= num_ovf ? (rhs_q[ACC_W-1] ? SUM_MIN : SUM_MAX) : num_raw;
            num_sat_reg <= sum_sat_reg | num_ovf;
            neg_reg     <= (num_ovf ? rhs_q[ACC_W-1] : num_raw[ACC_W-1]) ^ coeff_reg[DATA_W-1];
        end
        if (cmd.finish)
        begin
            out_idx_reg <= row_reg;
            out_val_reg <= sol_value;
            out_dz_reg  <= stat.coeff_zero;
            out_sat_reg <= num_sat_reg | quo_clamp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        m_axis_tdata                             = '0;
        m_axis_tdata[SOL_IDX_LSB +: IDX_W]       = out_idx_reg;
        m_axis_tdata[SOL_VAL_LSB +: DATA_W]      = out_val_reg;
        m_axis_tdata[DZ_BIT]                     = out_dz_reg;
        m_axis_tdata[SAT_BIT]                    = out_sat_reg;
    end

endmodule

/* hdl/lower_triangular_forward_solve.sv */
// Top level of the lower-triangular forward-substitution solver.
//
//  channel   dir  width  contents (lowest bit first)
//  --------  ---  -----  ---------------------------------------------------
//  s_axis    in   80     row_index[5:0], col_index[11:6], coeff[43:12],
//                        rhs[75:44], zero fill [79:76]
//  m_axis    out  40     sol_index[5:0], sol_value[37:6], div_zero[38],
//                        saturated[39]
//
// Off-diagonal transfer: accept and memory read, then multiply; the accumulate
// overlaps the next accept. Diagonal transfer: accept, numerator, divider start,
// the 32-step bit-serial divider, then finish; a zero diagonal skips the divider.
// Ignored items (column above the diagonal) are accepted and dropped. Reset clears
// the running sum, its saturation flag and all control state; the solution memory
// is not cleared, and the user must read each entry only once written (unchecked).
// A result waits in the output register; the solver keeps taking off-diagonal
// items meanwhile and stalls only when a second result is ready.
module lower_triangular_forward_solve
(
    input  logic                              clk,
    input  logic                              rst_n,
    // row_index, col_index, coeff, rhs
    input  logic [ltfs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sol_index, sol_value, div_zero, saturated
    output logic [ltfs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);
    import ltfs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: decides per transfer which datapath step runs
    ltfs_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // datapath: memory, MAC, numerator, divider, output register
    ltfs_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .stat          (stat)
    );

`ifndef SYNTHESIS
    // a finished row never overwrites a result still waiting downstream
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free)
        else $error("result loaded while output register busy");

    // a finished row shows up on the output in the next cycle
    a_finish_valid : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("finished row not presented");

    // zero diagonal forces a zero solution value
    a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[DZ_BIT]) |->
        (m_axis_tdata[SOL_VAL_LSB +: DATA_W] == '0))
        else $error("div_zero with nonzero value");

    // the divider cannot finish right after it was started
    a_div_len : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !stat.div_done)
        else $error("divider finished too early");
`endif

endmodule

/* dv/lower_triangular_forward_solve_tb.sv */
// Self-checking testbench for the lower-triangular forward-substitution solver.
`timescale 1ns / 100ps

module lower_triangular_forward_solve_tb;

    import ltfs_pkg::*;

    localparam int ITEMS       = 1950;     // counted items: off-diagonal and diagonal
    localparam int CYCLE_LIMIT = 1000000;  // far above the slowest legal run
    localparam int PRINT_MAX   = 30;       // cap on mismatch lines
    localparam int DRAIN_WAIT  = 40;       // one diagonal division plus margin

    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

    // One solution element as it leaves the m_axis side.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
        logic              dz;
        logic              sat;
    } sol_t;

    // One directed row: the item, plus an optional hand-written expectation.
    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] coeff;
        logic [DATA_W-1:0] rhs;
        logic              fixed;      // use the typed expectation below
        logic              fixed_out;  // typed row produces a result
        sol_t              want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    // Shadow copy of the solver state, updated on every accepted s_axis transfer that is not dropped.
    logic [DATA_W-1:0]       x_model [MAX_ORDER];
    bit                      x_known [MAX_ORDER];
    logic signed [ACC_W-1:0] run_sum     = '0;
    bit                      run_sum_sat = 1'b0;

    // Solution elements still owed by the solver, oldest first.
    sol_t awaited_solutions[$];

    int counted       = 0;   // accepted items that are not ignored by the solver
    int fail_count    = 0;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    lower_triangular_forward_solve dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #5 clk = ~clk;

    // Hard stop: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("lower_triangular_forward_solve: mismatch");
            $finish;
        end
    end

    // Advance the shadow solver by one item; return 1 when the item yields a solution.
    // Off-diagonal: add coeff * x[col] (exact Q32.32) to the running sum, clamp to
    // 64 bits. Diagonal: (rhs * 2^16 - sum) / coeff, truncate toward zero, clamp to
    // 32 bits; a zero coefficient forces 0 and flags div_zero.
    function automatic bit forward_solve_step(input logic [IDX_W-1:0] row,
                                              input logic [IDX_W-1:0] col,
                                              input logic [DATA_W-1:0] coeff,
                                              input logic [DATA_W-1:0] rhs,
                                              output sol_t res);
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W-1:0] num;
        logic [ACC_W:0]          wide;
        logic signed [ACC_W+1:0] n_ext;
        logic signed [ACC_W+1:0] d_ext;
        logic signed [ACC_W+1:0] quo;
        bit                      clamp;
        res = '0;
        // Column above the diagonal: drop without touching state.
        if (col > row)
            return 1'b0;
        a = $signed(coeff);
        if (col < row)
        begin
            b    = $signed(x_model[col]);
            prod = a * b;
            wide = {run_sum[ACC_W-1], run_sum} + {prod[ACC_W-1], prod};
            if (wide[ACC_W] != wide[ACC_W-1])
            begin
                run_sum     = wide[ACC_W] ? SUM_MIN : SUM_MAX;
                run_sum_sat = 1'b1;
            end
            else
                run_sum = wide[ACC_W-1:0];
            return 1'b0;
        end
        clamp = run_sum_sat;
        num   = $signed(rhs);
        num   = num <<< FRAC_W;
        wide  = {num[ACC_W-1], num} - {run_sum[ACC_W-1], run_sum};
        if (wide[ACC_W] != wide[ACC_W-1])
        begin
            num   = wide[ACC_W] ? SUM_MIN : SUM_MAX;
            clamp = 1'b1;
        end
        else
            num = wide[ACC_W-1:0];
        res.idx = row;
        res.dz  = (coeff == '0);
        if (!res.dz)
        begin
            n_ext = num;
            d_ext = $signed(coeff);
            quo   = n_ext / d_ext;
            if (quo > 66'sd2147483647)
            begin
                res.value = SOL_MAX;
                clamp     = 1'b1;
            end
            else if (quo < -66'sd2147483648)
            begin
                res.value = SOL_MIN;
                clamp     = 1'b1;
            end
            else
                res.value = quo[DATA_W-1:0];
        end
        res.sat      = clamp;
        x_model[row] = res.value;
        x_known[row] = 1'b1;
        run_sum      = '0;
        run_sum_sat  = 1'b0;
        return 1'b1;
    endfunction

    // Q16.16 operand: mostly small values around +-4.0, some full-range, some
    // extremes and some zeros (zero on a diagonal exercises the divide-by-zero path).
    function automatic logic [DATA_W-1:0] rand_q16();
        case ($urandom_range(9, 0))
            0:       return '0;
            1, 2:    return $urandom();
            3:
            begin
                case ($urandom_range(3, 0))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return 32'($urandom_range(32'h0008_0000, 0)) - 32'h0004_0000;
        endcase
    endfunction

    // Pick a column below row r whose solution is already known; the solver must
    // never read an element that no diagonal has written.
    function automatic bit pick_known_col(input int r, output logic [IDX_W-1:0] c);
        int cand[$];
        c = '0;
        for (int i = 0; i < r; i++)
            if (x_known[i])
                cand.push_back(i);
        if (cand.size() == 0)
            return 1'b0;
        c = IDX_W'(cand[$urandom_range(cand.size() - 1, 0)]);
        return 1'b1;
    endfunction

    // Drive one item on s_axis and hold it until the transfer completes, then
    // record what the solver owes for it.
    task automatic push_item(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                             input logic [DATA_W-1:0] coeff, input logic [DATA_W-1:0] rhs,
                             input bit fixed, input bit fixed_out, input sol_t want);
        sol_t res;
        bit   got;
        // Idle profile by progress: sender light / receiver heavy, then swapped,
        // then full throughput.
        if (counted < ITEMS / 3)
        begin
            send_idle_pct = 18;
            recv_idle_pct = 51;
        end
        else if (counted < 2 * ITEMS / 3)
        begin
            send_idle_pct = 51;
            recv_idle_pct = 18;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, rhs, coeff, col, row};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        got = forward_solve_step(row, col, coeff, rhs, res);
        if (fixed)
        begin
            got = fixed_out;
            res = want;
        end
        if (got)
            awaited_solutions.push_back(res);
        if (col <= row)
            counted++;
    endtask

    task automatic report(input string field, input logic [DATA_W-1:0] exp_v,
                          input logic [DATA_W-1:0] act_v);
        if (fail_count < PRINT_MAX)
            $display("%0t: %s expected %h actual %h", $time, field, exp_v, act_v);
        fail_count++;
    endtask

    // Result side: check every m_axis transfer against the oldest awaited
    // solution, then choose the next cycle's tready.
    always @(posedge clk)
    begin : result_sink
        sol_t got;
        sol_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.idx   = m_axis_tdata[SOL_IDX_LSB +: IDX_W];
            got.value = m_axis_tdata[SOL_VAL_LSB +: DATA_W];
            got.dz    = m_axis_tdata[DZ_BIT];
            got.sat   = m_axis_tdata[SAT_BIT];
            if (awaited_solutions.size() == 0)
                report("unexpected transfer, sol_index", '0, 32'(got.idx));
            else
            begin
                want = awaited_solutions.pop_front();
                if (got.idx != want.idx)
                    report("sol_index", 32'(want.idx), 32'(got.idx));
                if (got.value != want.value)
                    report("sol_value", want.value, got.value);
                if (got.dz != want.dz)
                    report("div_zero", 32'(want.dz), 32'(got.dz));
                if (got.sat != want.sat)
                    report("saturated", 32'(want.sat), 32'(got.sat));
            end
        end
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    initial
    begin
        dir_row_t         dir_tab[$];
        logic [IDX_W-1:0] c;
        int               r;
        int               n;
        int               pick;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // Directed rows. Typed expectations where the answer is obvious; the rest
        // go through the shadow solver.
        // Row 0: x0 = 5.0 / 1.0.
        dir_tab.push_back('{6'd0, 6'd0, Q_ONE, 32'h0005_0000, 1'b1, 1'b1,
                            '{6'd0, 32'h0005_0000, 1'b0, 1'b0}});
        // Row 1: (12.0 - 2.0 * x0) / 1.0 = 2.0.
        dir_tab.push_back('{6'd1, 6'd0, 32'h0002_0000, 32'h0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{6'd1, 6'd1, Q_ONE, 32'h000C_0000, 1'b1, 1'b1,
                            '{6'd1, 32'h0002_0000, 1'b0, 1'b0}});
        // Zero diagonal with a clean sum: value forced to 0, only div_zero set.
        dir_tab.push_back('{6'd2, 6'd2, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b1,
                            '{6'd2, 32'h0, 1'b1, 1'b0}});
        // Column above the diagonal: dropped, no result.
        dir_tab.push_back('{6'd3, 6'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0});
        // Negative diagonal: 3.0 / -1.0.
        dir_tab.push_back('{6'd4, 6'd4, 32'hFFFF_0000, 32'h0003_0000, 1'b1, 1'b1,
                            '{6'd4, 32'hFFFD_0000, 1'b0, 1'b0}});
        // Quotient overflow both ways, and a -1 divisor.
        dir_tab.push_back('{6'd5, 6'd5, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 1'b1,
                            '{6'd5, 32'h7FFF_FFFF, 1'b0, 1'b1}});
        dir_tab.push_back('{6'd6, 6'd6, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b1,
                            '{6'd6, 32'h8000_0000, 1'b0, 1'b1}});
        dir_tab.push_back('{6'd7, 6'd7, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1,
                            '{6'd7, 32'h8000_0000, 1'b0, 1'b1}});
        // Running sum clamps high: three near-2^62 products.
        for (int i = 0; i < 3; i++)
            dir_tab.push_back('{6'd9, 6'd5, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{6'd9, 6'd9, Q_ONE, 32'h0, 1'b0, 1'b0, '0});
        // Running sum clamps low, then the numerator clamps on the subtract.
        for (int i = 0; i < 3; i++)
            dir_tab.push_back('{6'd10, 6'd6, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{6'd10, 6'd10, Q_ONE, 32'h7FFF_FFFF, 1'b0, 1'b0, '0});
        // Zero diagonal after a clamped sum: both flags.
        for (int i = 0; i < 2; i++)
            dir_tab.push_back('{6'd11, 6'd6, 32'h8000_0000, 32'h0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{6'd11, 6'd11, 32'h0, 32'h8000_0000, 1'b1, 1'b1,
                            '{6'd11, 32'h0, 1'b1, 1'b1}});
        // Zero diagonal where only the numerator clamps.
        for (int i = 0; i < 2; i++)
            dir_tab.push_back('{6'd12, 6'd5, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{6'd12, 6'd12, 32'h0, 32'h8000_0000, 1'b1, 1'b1,
                            '{6'd12, 32'h0, 1'b1, 1'b1}});
        // Row change without a diagonal: the sum carries into row 63.
        dir_tab.push_back('{6'd13, 6'd0, Q_ONE, 32'h0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{6'd63, 6'd1, Q_ONE, 32'h0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{6'd63, 6'd63, Q_ONE, 32'h0010_0000, 1'b1, 1'b1,
                            '{6'd63, 32'h0009_0000, 1'b0, 1'b0}});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            push_item(dir_tab[i].row, dir_tab[i].col, dir_tab[i].coeff, dir_tab[i].rhs,
                      dir_tab[i].fixed, dir_tab[i].fixed_out, dir_tab[i].want);

        // Random part: mostly complete rows (known off-diagonals, then the diagonal),
        // some stray off-diagonals that leak into the next row, some dropped items.
        while (counted < ITEMS)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 8)
            begin
                r = $urandom_range(62, 0);
                push_item(IDX_W'(r), IDX_W'($urandom_range(63, r + 1)), $urandom(),
                          $urandom(), 1'b0, 1'b0, '0);
            end
            else if (pick < 14)
            begin
                r = $urandom_range(63, 1);
                if (pick_known_col(r, c))
                    push_item(IDX_W'(r), c, rand_q16(), rand_q16(), 1'b0, 1'b0, '0);
            end
            else
            begin
                r = $urandom_range(63, 0);
                n = $urandom_range(4, 0);
                for (int k = 0; k < n; k++)
                    if (pick_known_col(r, c))
                        push_item(IDX_W'(r), c, rand_q16(), rand_q16(), 1'b0, 1'b0, '0);
                push_item(IDX_W'(r), IDX_W'(r), rand_q16(), rand_q16(), 1'b0, 1'b0, '0);
            end
        end

        // Release the bus, drain, then give the solver time to show any extra result.
        s_axis_tvalid <= 1'b0;
        while (awaited_solutions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("lower_triangular_forward_solve: match");
        else
            $display("lower_triangular_forward_solve: mismatch");
        $finish;
    end

endmodule
